FILE: design/pbrle_pkg.sv
// Shared types and constants for the PackBits run-length decoder.
package pbrle_pkg;

   localparam int BYTES_PER_RESULT_DEF = 4;
   localparam int QUEUE_DEPTH_DEF      = 2;
   localparam int WORD_BYTES           = 4;

   localparam logic [7:0] NOOP_HEADER = 8'h80;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first_of_row;
   } req_beat_type;

   typedef struct packed {
      logic [31:0] out_word;
      logic [2:0]  byte_count;
      logic        last;
   } rsp_beat_type;

   // One expansion job: a data byte and how many copies of it to emit.
   typedef struct packed {
      logic [7:0] data;
      logic [7:0] count;
   } cmd_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_LITERAL = 3'b010,
      PH_REPEAT  = 3'b100
   } phase_type;

endpackage

FILE: design/pbrle_front.sv
// Front end: tracks headers and literal/repeat runs, issues expansion jobs.
module pbrle_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pbrle_pkg::req_beat_type req_beat,
   output logic                  push,
   output pbrle_pkg::cmd_type    push_cmd,
   input  logic                  queue_full
);
   import pbrle_pkg::*;

   phase_type  phase_ff, phase_in, eff_phase;
   logic [7:0] lit_ff, lit_in;
   logic [7:0] rep_ff, rep_in;
   logic       accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign eff_phase = req_beat.first_of_row ? PH_HEADER : phase_ff;

   always_comb begin
      phase_in      = phase_ff;
      lit_in        = lit_ff;
      rep_in        = rep_ff;
      push          = 1'b0;
      push_cmd.data = req_beat.in_byte;
      push_cmd.count = 8'd1;
      if (req_beat.first_of_row) begin
         lit_in = 8'd0;
         rep_in = 8'd0;
      end
      case (eff_phase)
         PH_LITERAL: begin
            push   = accept;
            lit_in = lit_ff - 8'd1;
            if (lit_ff == 8'd1) begin
               phase_in = PH_HEADER;
            end
         end
         PH_REPEAT: begin
            push           = accept;
            push_cmd.count = rep_ff;
            rep_in         = 8'd0;
            phase_in       = PH_HEADER;
         end
         default: begin
            if (!req_beat.in_byte[7]) begin
               lit_in   = req_beat.in_byte + 8'd1;
               phase_in = PH_LITERAL;
            end else if (req_beat.in_byte == NOOP_HEADER) begin
               phase_in = PH_HEADER;
            end else begin
               rep_in   = 8'(9'd257 - {1'b0, req_beat.in_byte});
               phase_in = PH_REPEAT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         lit_ff   <= 8'd0;
         rep_ff   <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         lit_ff   <= lit_in;
         rep_ff   <= rep_in;
      end
   end

endmodule

FILE: design/pbrle_queue.sv
// Small job queue between the front and back ends.
module pbrle_queue #(
   parameter int DEPTH = pbrle_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pbrle_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output pbrle_pkg::cmd_type head_cmd
);
   import pbrle_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type       mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_cmd  = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

FILE: design/pbrle_back.sv
// Back end: expands a job into result beats of up to four bytes.
module pbrle_back #(
   parameter int BYTES_PER_RESULT = pbrle_pkg::BYTES_PER_RESULT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   input  pbrle_pkg::cmd_type      job_cmd,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output pbrle_pkg::rsp_beat_type rsp_beat
);
   import pbrle_pkg::*;

   localparam int STEP = (BYTES_PER_RESULT > WORD_BYTES) ? WORD_BYTES :
                         (BYTES_PER_RESULT < 1) ? 1 : BYTES_PER_RESULT;

   logic       busy_ff, busy_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] left_ff, left_in;
   logic [2:0] take;
   logic       last_beat, sent;

   assign take      = (left_ff < 8'(STEP)) ? left_ff[2:0] : 3'(STEP);
   assign last_beat = (left_ff == {5'd0, take});
   assign sent      = busy_ff && !rsp_stall;
   assign pop       = !busy_ff || (sent && last_beat);

   assign rsp_valid           = busy_ff;
   assign rsp_beat.byte_count = take;
   assign rsp_beat.last      = last_beat;

   always_comb begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         rsp_beat.out_word[8*i +: 8] = (3'(i) < take) ? data_ff : 8'd0;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      data_in = data_ff;
      left_in = left_ff;
      if (sent) begin
         left_in = left_ff - {5'd0, take};
         if (last_beat) begin
            busy_in = 1'b0;
         end
      end
      if (pop && job_valid) begin
         busy_in = 1'b1;
         data_in = job_cmd.data;
         left_in = job_cmd.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      left_ff <= left_in;
   end

endmodule

FILE: design/packbits_rle_decoder_top.sv
// Top level of the PackBits run-length decoder.
// Takes one compressed byte per beat. Header bytes give no result. A literal
// byte gives one result beat; a repeat byte gives ceil(copies / N) beats
// (up to 32 at the default N of 4), N being BYTES_PER_RESULT clamped to 1..4,
// one per cycle from the back-end expander while rsp_stall is low. A small
// job queue sits between byte parsing and expansion, so headers and further
// data bytes are taken while a run is still being expanded; input stalls only
// when that queue is full. On its way to a result a data byte goes through the
// job queue storage and then the expander's output registers.
module packbits_rle_decoder_top #(
   parameter int BYTES_PER_RESULT = pbrle_pkg::BYTES_PER_RESULT_DEF,
   parameter int QUEUE_DEPTH      = pbrle_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  pbrle_pkg::req_beat_type req_beat,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output pbrle_pkg::rsp_beat_type rsp_beat
);
   import pbrle_pkg::*;

   logic    push, queue_full, pop, job_valid;
   cmd_type push_cmd, job_cmd;

   pbrle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_beat   (req_beat),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   pbrle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (job_valid),
      .head_cmd  (job_cmd)
   );

   pbrle_back #(
      .BYTES_PER_RESULT (BYTES_PER_RESULT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_cmd   (job_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("job pushed into full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_beat.byte_count != 3'd0) && (rsp_beat.byte_count <= 3'd4))
      else $error("result byte count out of range");

   a_short_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_beat.byte_count == 3'd1) && (BYTES_PER_RESULT > 1))
      |-> rsp_beat.last)
      else $error("partial result beat not marked last");

endmodule
